// ===== rtl/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 hasher package
// Shared payload types, command/status structs and SHA-1 constants.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam int WordW     = 32;
    localparam int NumWords  = 16;
    localparam int NumRounds = 80;
    localparam int CountW    = 61;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [7:0]  PadByte = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } sha1_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        final_word;
    } sha1_out_t;

    // byte source for the buffer
    typedef enum logic [1:0] {
        BSRC_DATA = 2'd0,
        BSRC_PAD  = 2'd1,
        BSRC_ZERO = 2'd2
    } byte_src_t;

    typedef struct packed {
        logic      push;        // write one byte into the buffer
        byte_src_t src;
        logic      count_inc;   // count a message byte
        logic      put_len;     // write the bit length into words 14/15
        logic      start;       // start a compression
        logic      reinit;      // restore initial state
        logic      load_out;    // present digest word out_idx
        logic [2:0] out_idx;
    } sha1_cmd_t;

    typedef struct packed {
        logic [5:0] fill;
        logic       busy;       // compression running
    } sha1_sts_t;

endpackage

// ===== rtl/sha1_message_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-1 message hasher
// Byte-serial SHA-1: one request per message byte, five digest words out.
// ----------------------------------------------------------------------------
// Usage:
//   in channel: each request carries data_byte, byte_present, end_of_message.
//   A request with byte_present adds one byte; end_of_message closes the
//   message (after its byte, if any), pads it and starts the digest.
//   out channel: five requests, digest words 0..4, final_word on the last.
// Timing:
//   The 64th byte of a block starts a compression (one round per cycle in the
//   datapath's round unit); the input is held off until it has finished.
//   Ending pads one byte per cycle while no compression runs, then one or
//   two compressions, then the digest words, one per cycle while the
//   receiver is ready.
// Reset: chaining value goes to the SHA-1 initial values, counts clear.
//   After the fifth word is taken the block returns to that state itself.
// Stall: a stalled output holds its word; no input is taken until all five
//   words have been delivered.
// ----------------------------------------------------------------------------
module sha1_message_hasher
    import sha1_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  sha1_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output sha1_out_t out_data
);

    sha1_cmd_t   cmd;
    sha1_sts_t   sts;
    logic [31:0] word;
    logic [2:0]  wnum;
    logic        fin;

    sha1_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_req      (in_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .word_number (wnum),
        .final_word  (fin),
        .sts         (sts),
        .cmd         (cmd)
    );

    sha1_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (in_data.data_byte),
        .sts       (sts),
        .out_word  (word)
    );

    assign out_data.digest_word = word;
    assign out_data.word_number = wnum;
    assign out_data.final_word  = fin;

endmodule

// ===== rtl/sha1_datapath.sv =====
// ----------------------------------------------------------------------------
// SHA-1 datapath
// Block buffer, byte counter, one-round-per-cycle compression and output reg.
// ----------------------------------------------------------------------------
module sha1_datapath
    import sha1_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sha1_cmd_t cmd,
    input  logic [7:0] data_byte,
    output sha1_sts_t sts,
    output logic [31:0] out_word
);

    logic [31:0] w_reg [NumWords];
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [6:0]  round_reg;
    logic        busy_reg;
    logic [5:0]  fill_reg;
    logic [CountW-1:0] count_reg;
    logic [31:0] out_reg;

    logic [7:0]  byte_val;
    logic [3:0]  widx;
    logic [1:0]  lane;
    logic [31:0] wr, wx, f, k, t;
    logic [3:0]  ri;

    always_comb
    begin
        unique case (cmd.src)
            BSRC_DATA: byte_val = data_byte;
            BSRC_PAD:  byte_val = PadByte;
            default:   byte_val = 8'h00;
        endcase
        widx = fill_reg[5:2];
        lane = fill_reg[1:0];
        ri   = round_reg[3:0];
        wx   = w_reg[ri + 4'd13] ^ w_reg[ri + 4'd8] ^ w_reg[ri + 4'd2] ^ w_reg[ri];
        wr   = (round_reg < 7'd16) ? w_reg[ri] : {wx[30:0], wx[31]};
        if (round_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg); k = K0;
        end
        else if (round_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg; k = K1;
        end
        else if (round_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg); k = K2;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg; k = K3;
        end
        t = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + wr;
    end

    // payload regs
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            unique case (lane)
                2'd0: w_reg[widx] <= {byte_val, 24'h0};
                2'd1: w_reg[widx][23:16] <= byte_val;
                2'd2: w_reg[widx][15:8]  <= byte_val;
                default: w_reg[widx][7:0] <= byte_val;
            endcase
        end
        if (cmd.put_len)
        begin
            w_reg[14] <= count_reg[CountW-1:29];
            w_reg[15] <= {count_reg[28:0], 3'b000};
        end
        if (busy_reg)
        begin
            if (round_reg >= 7'd16)
                w_reg[ri] <= wr;
            a_reg <= t; b_reg <= a_reg; c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg; e_reg <= d_reg;
        end
        else if (cmd.start)
        begin
            a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
            d_reg <= h_reg[3]; e_reg <= h_reg[4];
        end
        if (cmd.load_out)
            out_reg <= h_reg[cmd.out_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg[0] <= H0; h_reg[1] <= H1; h_reg[2] <= H2;
            h_reg[3] <= H3; h_reg[4] <= H4;
            busy_reg  <= 1'b0;
            round_reg <= '0;
            fill_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.push)
                fill_reg <= fill_reg + 6'd1;
            if (cmd.count_inc)
                count_reg <= count_reg + 1'b1;
            if (cmd.start)
            begin
                busy_reg  <= 1'b1;
                round_reg <= '0;
            end
            else if (busy_reg)
            begin
                round_reg <= round_reg + 7'd1;
                if (round_reg == 7'(NumRounds - 1))
                begin
                    busy_reg <= 1'b0;
                    h_reg[0] <= h_reg[0] + t;
                    h_reg[1] <= h_reg[1] + a_reg;
                    h_reg[2] <= h_reg[2] + {b_reg[1:0], b_reg[31:2]};
                    h_reg[3] <= h_reg[3] + c_reg;
                    h_reg[4] <= h_reg[4] + d_reg;
                end
            end
            if (cmd.reinit)
            begin
                h_reg[0] <= H0; h_reg[1] <= H1; h_reg[2] <= H2;
                h_reg[3] <= H3; h_reg[4] <= H4;
                fill_reg  <= '0;
                count_reg <= '0;
            end
        end
    end

    assign sts.fill = fill_reg;
    assign sts.busy = busy_reg;
    assign out_word = out_reg;

endmodule

// ===== rtl/sha1_ctrl.sv =====
// ----------------------------------------------------------------------------
// SHA-1 controller
// Sequences byte intake, padding, compressions and digest output.
// ----------------------------------------------------------------------------
module sha1_ctrl
    import sha1_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sha1_in_t  in_req,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      out_ready,
    output logic      out_valid,
    output logic [2:0] word_number,
    output logic      final_word,
    input  sha1_sts_t sts,
    output sha1_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_WAIT, S_PAD, S_LEN, S_FINAL, S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic       last_reg, last_next;
    logic [2:0] idx_reg, idx_next;
    logic       ov_reg, ov_next;
    logic       acc;

    assign in_ready    = (state_reg == S_IDLE);
    assign acc         = in_valid && in_ready;
    assign out_valid   = ov_reg;
    assign word_number = idx_reg;
    assign final_word  = (idx_reg == 3'd4);

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        cmd.src    = BSRC_DATA;
        cmd.out_idx = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    last_next = in_req.end_of_message;
                    if (in_req.byte_present)
                    begin
                        cmd.push = 1'b1;
                        cmd.count_inc = 1'b1;
                        if (sts.fill == 6'd63)
                        begin
                            cmd.start = 1'b1;
                            state_next = S_WAIT;
                        end
                        else if (in_req.end_of_message)
                            state_next = S_PAD;
                    end
                    else if (in_req.end_of_message)
                        state_next = S_PAD;
                end
            end
            S_WAIT:
            begin
                if (!sts.busy)
                    state_next = last_reg ? S_PAD : S_IDLE;
            end
            S_PAD:
            begin
                // 0x80 then zeros until fill reaches 56
                if (!sts.busy)
                begin
                    if (sts.fill == 6'd56 && last_reg == 1'b0)
                        state_next = S_LEN;
                    else
                    begin
                        cmd.push = 1'b1;
                        cmd.src  = last_reg ? BSRC_PAD : BSRC_ZERO;
                        last_next = 1'b0;
                        if (sts.fill == 6'd63)
                            cmd.start = 1'b1;
                    end
                end
            end
            S_LEN:
            begin
                cmd.put_len = 1'b1;
                cmd.start   = 1'b1;
                state_next  = S_FINAL;
            end
            S_FINAL:
            begin
                if (!sts.busy)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_idx  = 3'd0;
                    idx_next   = 3'd0;
                    ov_next    = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (idx_reg == 3'd4)
                    begin
                        ov_next    = 1'b0;
                        cmd.reinit = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.load_out = 1'b1;
                        cmd.out_idx  = idx_reg + 3'd1;
                        idx_next     = idx_reg + 3'd1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

// ===== rtl/sha1_checker.sv =====
// ----------------------------------------------------------------------------
// SHA-1 port checker
// Port-level properties of the hasher, bound to the top level.
// ----------------------------------------------------------------------------
module sha1_checker
    import sha1_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input sha1_out_t out_data
);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken during digest");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    a_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.final_word == (out_data.word_number == 3'd4)))
        else $error("final_word mismatch");

    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.final_word |=>
            out_valid && out_data.word_number == $past(out_data.word_number) + 3'd1)
        else $error("word order broken");

endmodule

bind sha1_message_hasher sha1_checker u_sha1_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// SHA-1 message hasher testbench
// Sends message bytes and end marks over the valid/ready request channel and
// checks every digest word against a behavioral SHA-1 kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
    import sha1_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    sha1_in_t  in_data;
    logic      out_valid;
    logic      out_ready;
    sha1_out_t out_data;

    sha1_message_hasher dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Bench-side SHA-1 state
    // ------------------------------------------------------------------
    logic [31:0] hash_state [5];
    logic [31:0] blk_buf [16];
    logic [60:0] byte_total;
    logic [5:0]  fill_level;

    sha1_out_t   digest_q [$];      // digest words still owed by the block

    int  err_count;
    int  sent_count;
    int  word_count;
    int  msg_count;
    int  idle_cycles;
    bit  timed_out;

    int  send_idle_pct;             // sender idle percentage
    int  recv_stall_pct;            // receiver stall percentage
    bit  hold_off;                  // long receiver hold-off active

    function automatic logic [31:0] rol(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    task automatic hash_init();
        hash_state[0] = H0;
        hash_state[1] = H1;
        hash_state[2] = H2;
        hash_state[3] = H3;
        hash_state[4] = H4;
        for (int i = 0; i < 16; i++)
            blk_buf[i] = '0;
        byte_total = '0;
        fill_level = '0;
    endtask

    // One 80-round compression of blk_buf into hash_state.
    task automatic compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t, wr;
        for (int i = 0; i < 16; i++)
            w[i] = blk_buf[i];
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r < 16)
                wr = w[r];
            else
            begin
                wr = rol(w[(r + 13) & 15] ^ w[(r + 8) & 15] ^ w[(r + 2) & 15]
                         ^ w[r & 15], 1);
                w[r & 15] = wr;
            end
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = K0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = K1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K3;
            end
            t = rol(a, 5) + f + e + k + wr;
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
    endtask

    task automatic buffer_byte(input logic [7:0] bv);
        int idx;
        int lane;
        idx  = fill_level[5:2];
        lane = fill_level[1:0];
        if (lane == 0)
            blk_buf[idx] = {bv, 24'h0};
        else
            blk_buf[idx] |= 32'(bv) << (24 - 8 * lane);
        fill_level++;
        if (fill_level == 0)
            compress_block();
    endtask

    // Advance the bench hash by one request; queue digest words on end mark.
    task automatic predict_digest(input sha1_in_t req);
        logic [63:0] bit_len;
        sha1_out_t   w;
        if (req.byte_present)
        begin
            byte_total++;
            buffer_byte(req.data_byte);
        end
        if (!req.end_of_message)
            return;
        bit_len = {byte_total, 3'b000};
        buffer_byte(PadByte);
        while (fill_level != 6'd56)
            buffer_byte(8'h00);
        blk_buf[14] = bit_len[63:32];
        blk_buf[15] = bit_len[31:0];
        compress_block();
        for (int i = 0; i < 5; i++)
        begin
            w.digest_word = hash_state[i];
            w.word_number = 3'(i);
            w.final_word  = (i == 4);
            digest_q.push_back(w);
        end
        msg_count++;
        hash_init();
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h (word %0d)", what, got, want,
                 word_count);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Sender: one request, held until accepted
    // ------------------------------------------------------------------
    task automatic send_request(input logic [7:0] bv, input bit present,
                                input bit last);
        sha1_in_t req;
        req.data_byte      = bv;
        req.byte_present   = present;
        req.end_of_message = last;
        // random idle gap ahead of the request
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // accepted at this edge
        predict_digest(req);
        sent_count++;
    endtask

    task automatic send_bytes(input int n);
        for (int i = 0; i < n; i++)
            send_request(8'($urandom), 1'b1, 1'b0);
    endtask

    // Drop the request line, then wait until every queued digest word is back.
    task automatic drain();
        in_valid <= 1'b0;
        while (digest_q.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, driven at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker: compare each accepted word with the oldest expectation.
    always @(posedge clk)
    begin
        sha1_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (digest_q.size() == 0)
            begin
                report_mismatch("unexpected word", out_data.digest_word, '0);
            end
            else
            begin
                want = digest_q.pop_front();
                if (out_data.digest_word !== want.digest_word)
                    report_mismatch("digest_word", out_data.digest_word,
                                    want.digest_word);
                if (out_data.word_number !== want.word_number)
                    report_mismatch("word_number", 32'(out_data.word_number),
                                    32'(want.word_number));
                if (out_data.final_word !== want.final_word)
                    report_mismatch("final_word", 32'(out_data.final_word),
                                    32'(want.final_word));
            end
            word_count++;
        end
    end

    // Watchdog: cycles with no handshake on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000 && !timed_out)
        begin
            timed_out = 1'b1;
            $display("Watchdog expired");
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty message, end with byte, no-op items, boundary byte values.
    task automatic test_directed();
        send_request(8'h00, 1'b0, 1'b1);            // empty message
        send_request(8'hFF, 1'b0, 1'b0);            // ignored item
        send_request(8'h61, 1'b1, 1'b0);            // "abc"
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h63, 1'b1, 1'b1);            // end carries a byte
        send_request(8'hFF, 1'b1, 1'b0);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'hAA, 1'b0, 1'b0);            // ignored in mid message
        send_request(8'h55, 1'b1, 1'b0);
        send_request(8'h00, 1'b0, 1'b1);            // end without byte
        send_request(8'hFF, 1'b1, 1'b1);            // one-byte message
        drain();
    endtask

    // Lengths around the padding boundaries (55/56/63/64 bytes).
    task automatic test_pad_boundaries();
        int lens [4] = '{55, 56, 63, 64};
        foreach (lens[i])
        begin
            send_bytes(lens[i] - 1);
            send_request(8'($urandom), 1'b1, 1'b1);
        end
        drain();
    endtask

    // Random messages: mostly short, noise items mixed in.
    task automatic test_random(input int budget);
        int len;
        int start;
        start = sent_count;
        while (sent_count - start < budget)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(130)
                                           : $urandom_range(20);
            if (len > budget - (sent_count - start))
                len = budget - (sent_count - start);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(7) == 0)
                    send_request(8'($urandom), 1'b0, 1'b0);
                send_request(8'($urandom), 1'b1, 1'b0);
            end
            send_request(8'($urandom), 1'($urandom), 1'b1);
        end
        drain();
    endtask

    // Receiver holds off while messages keep coming, so the block backs up.
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int m = 0; m < 3; m++)
                begin
                    send_bytes(3);
                    send_request(8'($urandom), 1'b1, 1'b1);
                end
            end
        join
        drain();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        hold_off       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        err_count      = 0;
        sent_count     = 0;
        word_count     = 0;
        msg_count      = 0;
        idle_cycles    = 0;
        timed_out      = 1'b0;
        hash_init();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_pad_boundaries();

        // idling phases over the random traffic
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random(37);
        send_idle_pct = 55; recv_stall_pct = 0;  test_random(37);
        send_idle_pct = 0;  recv_stall_pct = 55; test_random(37);
        send_idle_pct = 8;  recv_stall_pct = 8;  test_random(37);
        send_idle_pct = 0;  recv_stall_pct = 0;  test_backpressure();

        drain();
        repeat (200) @(posedge clk);

        $display("Covered %0d requests, %0d messages, %0d digest words checked",
                 sent_count, msg_count, word_count);
        $display("Included empty, padding-boundary and multi-block messages");
        if (err_count == 0 && digest_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
